@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain check, sampled on the rising clock edge, off while in reset.
`define PFR_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Implication in the same cycle.
`define PFR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/pfr_pkg.sv @@
`default_nettype none

package pfr_pkg;

	// register index, decoded from paddr[2]
	localparam logic REG_AXIS_START = 1'b0;
	localparam logic REG_BIN_WIDTH  = 1'b1;

	localparam logic [13:0] AXIS_START_RST = 14'd0;
	localparam logic [10:0] BIN_WIDTH_RST  = 11'd16;

	// 2.5 in units of 1/1024
	localparam logic [13:0] NARROW_LIMIT = 14'd2560;

	localparam logic [11:0] MINW_L_NARROW = 12'd51;
	localparam logic [11:0] MINW_L_WIDE   = 12'd246;
	localparam logic [11:0] MINW_R_NARROW = 12'd51;
	localparam logic [11:0] MINW_R_WIDE   = 12'd358;
	localparam logic [11:0] MAXD_L_NARROW = 12'd819;
	localparam logic [11:0] MAXD_L_WIDE   = 12'd614;
	localparam logic [11:0] MAXD_R_NARROW = 12'd2048;
	localparam logic [11:0] MAXD_R_WIDE   = 12'd717;

	localparam int QUEUE_DEPTH = 4;

	// one classified request on its way from front to back
	typedef struct packed {
		logic        is_query;
		logic [23:0] content;
		logic [13:0] peak;
		logic        narrow;
		logic [13:0] diff;     // peak - axis_start, zero below the axis
	} q_entry_t;

endpackage

`default_nettype wire

@@ rtl/pfr_in_if.sv @@
`default_nettype none

interface pfr_in_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [23:0] bin_content;
	logic [13:0] peak_charge;

	modport source (output valid, req_type, bin_content, peak_charge, input ready);
	modport sink (input valid, req_type, bin_content, peak_charge, output ready);
endinterface

`default_nettype wire

@@ rtl/pfr_out_if.sv @@
`default_nettype none

interface pfr_out_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] low_edge;
	logic        [14:0] high_edge;
	logic               no_data;

	modport source (output valid, low_edge, high_edge, no_data, input ready);
	modport sink (input valid, low_edge, high_edge, no_data, output ready);
endinterface

`default_nettype wire

@@ rtl/pfr_front.sv @@
`default_nettype none

module pfr_front (
	pfr_in_if.sink            items,
	input  wire logic [13:0]  axis_start,
	output pfr_pkg::q_entry_t push_data,
	output logic              push_valid,
	input  wire logic         push_ready
);

	assign push_valid  = items.valid;
	assign items.ready = push_ready;

	always_comb begin
		push_data          = '0;
		push_data.is_query = items.req_type;
		push_data.content  = items.bin_content;
		push_data.peak     = items.peak_charge;
		push_data.narrow   = items.peak_charge < pfr_pkg::NARROW_LIMIT;
		if (items.peak_charge < axis_start) begin
			push_data.diff = '0;
		end else begin
			push_data.diff = items.peak_charge - axis_start;
		end
	end

endmodule

`default_nettype wire

@@ rtl/pfr_queue.sv @@
`default_nettype none

module pfr_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pfr_pkg::q_entry_t push_data,
	input  wire logic              push_valid,
	output logic                   push_ready,
	output pfr_pkg::q_entry_t      pop_data,
	output logic                   pop_valid,
	input  wire logic              pop_ready
);

	localparam int DEPTH = pfr_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	pfr_pkg::q_entry_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/pfr_back.sv @@
`default_nettype none

module pfr_back #(
	parameter int MAX_BINS = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [13:0]                    axis_start,
	input  wire logic [10:0]                    bin_width,
	input  wire pfr_pkg::q_entry_t              pop_data,
	input  wire logic                           pop_valid,
	output logic                                pop_ready,
	pfr_out_if.source                           results,
	output logic [$clog2(MAX_BINS + 1)-1:0]     bins_loaded
);

	localparam int CNT_W  = $clog2(MAX_BINS + 1);
	localparam int IDX_W  = $clog2(MAX_BINS);
	localparam int PROD_W = CNT_W + 11;
	localparam int PW     = CNT_W + 14;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_IDX, ST_PK_RD, ST_PK_GET, ST_LT_RD, ST_LT_CHK,
		ST_RT_RD, ST_RT_CHK, ST_MUL_L, ST_MUL_H, ST_SUM, ST_DONE
	} state_t;

	state_t state_q;

	logic [23:0] mem [MAX_BINS];
	logic [23:0] rdata_q;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;

	logic [CNT_W-1:0]  cnt_q, n_q;
	logic [13:0]       z_q, quo_q;
	logic              narrow_q, nd_q, lfound_q, hfound_q;
	logic [10:0]       rem_q;
	logic [3:0]        step_q;
	logic [IDX_W-1:0]  idx_q, scan_q, lidx_q;
	logic [24:0]       target_q;
	logic [PROD_W-1:0] prod_q;
	logic signed [PW-1:0] low_q, high_q;

	logic               ov_q, ond_q;
	logic signed [14:0] ol_q;
	logic [14:0]        oh_q;

	logic [10:0] bw_eff, half;
	logic [11:0] div_sh;
	logic        div_ge;
	logic [27:0] times10;
	logic        hit, out_free, out_load;
	logic [11:0] minl, minr, maxl, maxr;
	logic signed [PW-1:0] zs, axis_s, half_s, prod_s;
	logic signed [PW-1:0] lo_min, lo_max, lo_a, lo_b, hi_min, hi_max, hi_a, hi_b;
	logic [CNT_W-1:0] hmul;

	assign bw_eff  = (bin_width == '0) ? 11'd1 : bin_width;
	assign half    = bw_eff >> 1;
	assign div_sh  = {rem_q, quo_q[13]};
	assign div_ge  = div_sh >= {1'b0, bw_eff};
	assign times10 = {1'b0, rdata_q, 3'b000} + {3'b000, rdata_q, 1'b0};
	assign hit     = times10 < {3'b000, target_q};
	assign out_free = !ov_q || results.ready;
	assign out_load = (state_q == ST_DONE) && out_free;

	assign wr_en = (state_q == ST_IDLE) && pop_valid && !pop_data.is_query
		&& (cnt_q < CNT_W'(MAX_BINS));
	assign rd_addr   = (state_q == ST_PK_RD) ? idx_q : scan_q;
	assign pop_ready = state_q == ST_IDLE;

	assign minl = narrow_q ? pfr_pkg::MINW_L_NARROW : pfr_pkg::MINW_L_WIDE;
	assign minr = narrow_q ? pfr_pkg::MINW_R_NARROW : pfr_pkg::MINW_R_WIDE;
	assign maxl = narrow_q ? pfr_pkg::MAXD_L_NARROW : pfr_pkg::MAXD_L_WIDE;
	assign maxr = narrow_q ? pfr_pkg::MAXD_R_NARROW : pfr_pkg::MAXD_R_WIDE;

	assign zs     = PW'(z_q);
	assign axis_s = PW'(axis_start);
	assign half_s = PW'(half);
	assign prod_s = PW'(prod_q);
	assign hmul   = hfound_q ? CNT_W'(scan_q) : n_q;

	// left edge: not above z - min, not below z - max
	assign lo_min = zs - PW'(minl);
	assign lo_max = zs - PW'(maxl);
	assign lo_a   = (low_q > lo_min) ? lo_min : low_q;
	assign lo_b   = (lo_a < lo_max) ? lo_max : lo_a;
	// right edge: not below z + min, not above z + max
	assign hi_min = zs + PW'(minr);
	assign hi_max = zs + PW'(maxr);
	assign hi_a   = (high_q < hi_min) ? hi_min : high_q;
	assign hi_b   = (hi_a > hi_max) ? hi_max : hi_a;

	assign results.valid     = ov_q;
	assign results.low_edge  = ol_q;
	assign results.high_edge = oh_q;
	assign results.no_data   = ond_q;
	assign bins_loaded       = cnt_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[IDX_W-1:0]] <= pop_data.content;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			ov_q     <= 1'b0;
			n_q      <= '0;
			z_q      <= '0;
			quo_q    <= '0;
			rem_q    <= '0;
			step_q   <= '0;
			narrow_q <= 1'b0;
			nd_q     <= 1'b0;
			lfound_q <= 1'b0;
			hfound_q <= 1'b0;
			idx_q    <= '0;
			scan_q   <= '0;
			lidx_q   <= '0;
			target_q <= '0;
			prod_q   <= '0;
			low_q    <= '0;
			high_q   <= '0;
			ol_q     <= '0;
			oh_q     <= '0;
			ond_q    <= 1'b0;
		end else begin
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (results.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						if (!pop_data.is_query) begin
							if (wr_en) begin
								cnt_q <= cnt_q + CNT_W'(1);
							end
						end else begin
							n_q      <= cnt_q;
							cnt_q    <= '0;
							z_q      <= pop_data.peak;
							narrow_q <= pop_data.narrow;
							quo_q    <= pop_data.diff;
							rem_q    <= '0;
							step_q   <= '0;
							nd_q     <= cnt_q == '0;
							state_q  <= (cnt_q == '0) ? ST_DONE : ST_DIV;
						end
					end
				end
				ST_DIV: begin
					// restoring divide, one quotient bit per cycle
					rem_q  <= div_ge ? 11'(div_sh - {1'b0, bw_eff}) : div_sh[10:0];
					quo_q  <= {quo_q[12:0], div_ge};
					step_q <= step_q + 4'd1;
					if (step_q == 4'd13) begin
						state_q <= ST_IDX;
					end
				end
				ST_IDX: begin
					if (32'(quo_q) >= 32'(n_q)) begin
						idx_q <= IDX_W'(n_q - CNT_W'(1));
					end else begin
						idx_q <= IDX_W'(quo_q);
					end
					state_q <= ST_PK_RD;
				end
				ST_PK_RD: begin
					state_q <= ST_PK_GET;
				end
				ST_PK_GET: begin
					target_q <= narrow_q ? {rdata_q, 1'b0} : {1'b0, rdata_q};
					scan_q   <= idx_q;
					state_q  <= ST_LT_RD;
				end
				ST_LT_RD: begin
					state_q <= ST_LT_CHK;
				end
				ST_LT_CHK: begin
					if (hit || scan_q == '0) begin
						lfound_q <= hit;
						lidx_q   <= scan_q;
						scan_q   <= idx_q;
						state_q  <= ST_RT_RD;
					end else begin
						scan_q  <= scan_q - IDX_W'(1);
						state_q <= ST_LT_RD;
					end
				end
				ST_RT_RD: begin
					state_q <= ST_RT_CHK;
				end
				ST_RT_CHK: begin
					if (hit || (CNT_W'(scan_q) + CNT_W'(1) == n_q)) begin
						hfound_q <= hit;
						state_q  <= ST_MUL_L;
					end else begin
						scan_q  <= scan_q + IDX_W'(1);
						state_q <= ST_RT_RD;
					end
				end
				ST_MUL_L: begin
					prod_q  <= PROD_W'(lidx_q) * PROD_W'(bw_eff);
					state_q <= ST_MUL_H;
				end
				ST_MUL_H: begin
					low_q   <= lfound_q ? (axis_s + prod_s + half_s) : axis_s;
					prod_q  <= PROD_W'(hmul) * PROD_W'(bw_eff);
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					high_q  <= axis_s + prod_s + (hfound_q ? half_s : '0);
					low_q   <= lo_b;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						ond_q   <= nd_q;
						ol_q    <= nd_q ? '0 : low_q[14:0];
						oh_q    <= nd_q ? '0 : hi_b[14:0];
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/peak_fraction_range_finder.sv @@
// Peak fraction range finder.
// Requests come in on "items": req_type 0 appends bin_content as the next
// histogram bin, req_type 1 runs a range search around peak_charge. Each
// search gives one result on "results" (low_edge, high_edge, no_data);
// loads give none. axis_start and bin_width are set over the APB port
// (byte address 0 and 4); the user must write them only while the block
// is idle, which the block does not enforce. A front stage classifies each
// request into a 4-entry queue; the back sequencer pops it. Loads drain
// one per cycle while no search is under way, so a stream of loads runs
// at one per cycle. A search pops from the queue, then visits the peak bin
// and the bins left and right of it: the 14-step shift-subtract divider
// finds the peak bin, then each bin costs one read and one compare on the
// single read port of the bin store. With no bins a search skips all this.
// Reset clears the bin count, the queue and the result register; the bin
// store itself is not cleared and needs no sweep. While the receiver holds
// ready low, the result waits in its register; the back side finishes its
// next search and then waits, and the queue fills and lowers items.ready.
`default_nettype none
`include "assert_macros.svh"

module peak_fraction_range_finder #(
	parameter int MAX_BINS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	pfr_in_if.sink           items,
	pfr_out_if.source        results
);

	localparam int CNT_W = $clog2(MAX_BINS + 1);

	logic [13:0] axis_start_q;
	logic [10:0] bin_width_q;

	pfr_pkg::q_entry_t push_data, pop_data;
	logic              push_valid, push_ready, pop_valid, pop_ready;
	logic [CNT_W-1:0]  bins_loaded;

	// register file: writes land on the access phase, reads are plain muxing
	assign pready = 1'b1;

	always_comb begin
		case (paddr[2])
			pfr_pkg::REG_AXIS_START: prdata = {18'd0, axis_start_q};
			pfr_pkg::REG_BIN_WIDTH:  prdata = {21'd0, bin_width_q};
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_start_q <= pfr_pkg::AXIS_START_RST;
			bin_width_q  <= pfr_pkg::BIN_WIDTH_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				pfr_pkg::REG_AXIS_START: axis_start_q <= pwdata[13:0];
				pfr_pkg::REG_BIN_WIDTH:  bin_width_q  <= pwdata[10:0];
				default: begin
				end
			endcase
		end
	end

	// front: classify and offset the peak against the axis
	pfr_front u_front (
		.items      (items),
		.axis_start (axis_start_q),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// decoupling queue
	pfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	// back: bin store, divider, scans, clamping, result register
	pfr_back #(
		.MAX_BINS (MAX_BINS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.axis_start  (axis_start_q),
		.bin_width   (bin_width_q),
		.pop_data    (pop_data),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.results     (results),
		.bins_loaded (bins_loaded)
	);

	// empty histogram reports zero edges
	`PFR_ASSERT_IMPL(a_no_data_zero, results.valid && results.no_data, results.low_edge == 15'sd0 && results.high_edge == 15'd0, "no_data result with nonzero edges")

	// clamping keeps the right edge above the left one
	`PFR_ASSERT_IMPL(a_edge_order, results.valid && !results.no_data, $signed(16'(results.high_edge)) > $signed(16'(results.low_edge)), "high_edge not above low_edge")

	// bin count never runs past the store
	`PFR_ASSERT(a_cnt_bound, bins_loaded <= CNT_W'(MAX_BINS), "bin count beyond store depth")

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// request codes on the items channel
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	// fixed-point thresholds and distances, units of 1/1024
	localparam longint NARROW_Q    = 2560;
	localparam longint MIN_L_NAR   = 51;
	localparam longint MIN_L_WIDE  = 246;
	localparam longint MIN_R_NAR   = 51;
	localparam longint MIN_R_WIDE  = 358;
	localparam longint MAX_L_NAR   = 819;
	localparam longint MAX_L_WIDE  = 614;
	localparam longint MAX_R_NAR   = 2048;
	localparam longint MAX_R_WIDE  = 717;

	localparam int STORE_DEPTH    = 1024;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int MAX_REPORTS    = 10;
	localparam int PHASE_ITEMS    = 56;

	typedef struct {
		logic        kind;
		logic [23:0] content;
		logic [13:0] peak;
	} hist_req_t;

	typedef struct {
		logic signed [14:0] low;
		logic        [14:0] high;
		logic               no_data;
	} range_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pfr_in_if  items_if();
	pfr_out_if results_if();

	peak_fraction_range_finder u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.items   (items_if),
		.results (results_if)
	);

	// shadow of the block: histogram store, bin count and both registers
	logic [23:0] hist_bins [STORE_DEPTH];
	int          hist_count;
	logic [13:0] axis_lo;
	logic [10:0] bin_w;

	hist_req_t req_q[$];        // requests waiting for the driver
	range_t    range_exp_q[$];  // predicted search results, oldest first

	int pushed_total;
	int reqs_seen;
	int searches;
	int empty_searches;
	int cfg_writes;
	int fail_count;
	int quiet_cycles;
	int leftover;

	bit        req_taken;
	int        gap_left;
	int        stall_left;
	bit        in_calm;
	bit        out_calm;
	hist_req_t cur_req;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Gap length: mostly none or short, now and then long. While "calm" the
	// side runs flat out, which gives stretches with no idling at all.
	function automatic int draw_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic longint bin_center(input int k, input longint bw);
		return longint'(axis_lo) + k * bw + (bw >> 1);
	endfunction

	// Range search over the n loaded bins around peak position pk.
	function automatic range_t search_range(input logic [13:0] pk, input int n);
		longint bw, z, ax, quot, lo, hi, target;
		longint minl, minr, maxl, maxr;
		int     idx;
		bit     narrow;
		range_t r;
		bw = (bin_w == 0) ? 1 : longint'(bin_w);
		z  = longint'(pk);
		ax = longint'(axis_lo);
		// peak bin, saturated to the loaded range on both sides
		if (z < ax) begin
			idx = 0;
		end else begin
			quot = (z - ax) / bw;
			idx  = (quot >= n) ? n - 1 : int'(quot);
		end
		narrow = z < NARROW_Q;
		// fraction compared exactly: content*10 < peak*2 (narrow) or peak*1
		target = longint'(hist_bins[idx]) * (narrow ? 2 : 1);
		lo = ax;
		for (int k = idx; k >= 0; k--) begin
			if (longint'(hist_bins[k]) * 10 < target) begin
				lo = bin_center(k, bw);
				break;
			end
		end
		hi = ax + n * bw;
		for (int k = idx; k < n; k++) begin
			if (longint'(hist_bins[k]) * 10 < target) begin
				hi = bin_center(k, bw);
				break;
			end
		end
		minl = narrow ? MIN_L_NAR : MIN_L_WIDE;
		minr = narrow ? MIN_R_NAR : MIN_R_WIDE;
		maxl = narrow ? MAX_L_NAR : MAX_L_WIDE;
		maxr = narrow ? MAX_R_NAR : MAX_R_WIDE;
		// min distance first, then max distance, same order as the block
		if (lo > z - minl) lo = z - minl;
		if (lo < z - maxl) lo = z - maxl;
		if (hi < z + minr) hi = z + minr;
		if (hi > z + maxr) hi = z + maxr;
		r.low     = lo[14:0];
		r.high    = hi[14:0];
		r.no_data = 1'b0;
		return r;
	endfunction

	// Update the shadow with one accepted request; a search predicts a result.
	task automatic apply_request(input logic kind, input logic [23:0] content,
			input logic [13:0] pk);
		range_t r;
		int     n;
		if (kind == REQ_LOAD) begin
			// loads past the end of the store are dropped
			if (hist_count < STORE_DEPTH) begin
				hist_bins[hist_count] = content;
				hist_count++;
			end
		end else begin
			n = hist_count;
			hist_count = 0;
			searches++;
			if (n == 0) begin
				empty_searches++;
				r.low     = '0;
				r.high    = '0;
				r.no_data = 1'b1;
			end else begin
				r = search_range(pk, n);
			end
			range_exp_q.insert(range_exp_q.size(), r);
		end
	endtask

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	task automatic check_result();
		range_t e;
		if (range_exp_q.size() == 0) begin
			note_failure($sformatf("unexpected result low %0d high %0d no_data %0d",
				results_if.low_edge, results_if.high_edge, results_if.no_data));
		end else begin
			e = range_exp_q.pop_front();
			if (results_if.low_edge !== e.low || results_if.high_edge !== e.high ||
					results_if.no_data !== e.no_data)
				note_failure($sformatf(
					"range mismatch: exp low %0d high %0d no_data %0d, got low %0d high %0d no_data %0d",
					e.low, e.high, e.no_data,
					results_if.low_edge, results_if.high_edge, results_if.no_data));
		end
	endtask

	// Sample both channels at the rising edge; keep the watchdog count.
	always @(posedge clk) begin
		req_taken = 1'b0;
		if (arst_n) begin
			req_taken = items_if.valid && items_if.ready;
			if (req_taken) begin
				apply_request(items_if.req_type, items_if.bin_content,
					items_if.peak_charge);
				reqs_seen++;
			end
			if (results_if.valid && results_if.ready)
				check_result();
			if (req_taken || (results_if.valid && results_if.ready) ||
					(psel && penable && pwrite))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// Request driver: holds a request until taken, then idles a random gap.
	always @(negedge clk) begin
		if (arst_n && (!items_if.valid || req_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				items_if.valid <= 1'b0;
			end else if (req_q.size() > 0) begin
				cur_req = req_q.pop_front();
				items_if.valid       <= 1'b1;
				items_if.req_type    <= cur_req.kind;
				items_if.bin_content <= cur_req.content;
				items_if.peak_charge <= cur_req.peak;
				if ($urandom_range(0, 39) == 0)
					in_calm = !in_calm;
				gap_left = draw_gap(in_calm);
			end else begin
				items_if.valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls on ready.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= 1'b1;
				if ($urandom_range(0, 39) == 0)
					out_calm = !out_calm;
				stall_left = draw_gap(out_calm);
			end
		end
	end

	// Ends a run in which nothing moves for too long.
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(negedge clk);
		$display("timeout: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
		$display("tb_top failed");
		$finish;
	end

	task automatic push_load(input logic [23:0] content);
		hist_req_t r;
		r.kind    = REQ_LOAD;
		r.content = content;
		r.peak    = $urandom_range(0, 16383);  // unused on loads
		req_q.insert(req_q.size(), r);
		pushed_total++;
	endtask

	task automatic push_search(input logic [13:0] pk);
		hist_req_t r;
		r.kind    = REQ_SEARCH;
		r.content = $urandom_range(0, 24'hFFFFFF);  // unused on searches
		r.peak    = pk;
		req_q.insert(req_q.size(), r);
		pushed_total++;
	endtask

	// APB write: setup cycle, then access cycle; pready is always high.
	task automatic cfg_write(input logic idx, input int value);
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		if (idx == pfr_pkg::REG_AXIS_START)
			axis_lo = value[13:0];
		else
			bin_w = value[10:0];
		cfg_writes++;
	endtask

	// Wait until every request is taken and every result is in, then idle on.
	task automatic settle(input int extra);
		while (reqs_seen < pushed_total || range_exp_q.size() > 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	// Peaked histogram: Lorentz-like hump around a random bin, a little noise.
	task automatic push_profile(input int nb, output int c);
		longint amp, d, s;
		c   = $urandom_range(0, nb - 1);
		s   = $urandom_range(1, 6);
		amp = $urandom_range(0, 24'hFFFFFF);
		for (int i = 0; i < nb; i++) begin
			d = i - c;
			if ($urandom_range(0, 19) == 0)
				push_load($urandom_range(0, 24'hFFFFFF));
			else
				push_load(24'(amp * s * s / (s * s + d * d)));
		end
	endtask

	// Peak placed inside bin c, or just below the axis now and then.
	function automatic logic [13:0] peak_near(input int c);
		longint bwe, z;
		bwe = (bin_w == 0) ? 1 : longint'(bin_w);
		z   = longint'(axis_lo) + c * bwe + $urandom_range(0, int'(bwe - 1));
		if ($urandom_range(0, 7) == 0 && axis_lo > 50)
			z = longint'(axis_lo) - $urandom_range(1, 50);
		if (z > 16383)
			z = 16383;
		return z[13:0];
	endfunction

	// One random load/search sequence; most are well formed.
	task automatic push_sequence();
		int kind, r, nb, c;
		kind = $urandom_range(0, 99);
		r    = $urandom_range(0, 99);
		nb   = (r < 70) ? $urandom_range(1, 12) :
			(r < 92) ? $urandom_range(13, 40) : $urandom_range(41, 150);
		if (kind < 80) begin
			push_profile(nb, c);
			push_search(peak_near(c));
		end else if (kind < 90) begin
			// noise: random contents, peak anywhere
			for (int i = 0; i < nb; i++)
				push_load($urandom_range(0, 24'hFFFFFF));
			push_search($urandom_range(0, 16383));
		end else if (kind < 95) begin
			// search with the store empty
			push_search($urandom_range(0, 16383));
		end else begin
			push_profile(nb, c);
			push_search($urandom_range(0, 16383));
		end
	endtask

	initial begin
		int ax, bw, c, start;
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		items_if.valid       = 1'b0;
		items_if.req_type    = REQ_LOAD;
		items_if.bin_content = '0;
		items_if.peak_charge = '0;
		results_if.ready     = 1'b0;
		hist_count = 0;
		axis_lo    = pfr_pkg::AXIS_START_RST;
		bin_w      = pfr_pkg::BIN_WIDTH_RST;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, reset configuration (axis 0, width 16).
		push_search(14'd0);                      // nothing loaded
		push_load(24'hFFFFFF);
		push_search(14'h3FFF);                   // peak past the axis end
		push_load(24'd0);
		push_load(24'hFFFFFF);
		push_load(24'd0);
		push_search(14'd24);                     // narrow, left edge negative
		push_load(24'd5);
		push_load(24'd5);
		push_load(24'd5);
		push_search(14'd40);                     // no bin qualifies
		push_load(24'd100);
		push_load(24'd1000);
		push_load(24'd100000);
		push_load(24'd1000);
		push_load(24'd100);
		push_search(14'd3000);                   // wide, saturated to last bin
		push_search(14'd100);                    // back-to-back search
		push_load(24'd0);
		push_search(14'd8);                      // zero peak content
		push_load(24'd10);
		push_load(24'd50);
		push_search(14'd2559);                   // last narrow position
		push_load(24'd10);
		push_load(24'd50);
		push_search(14'd2560);                   // first wide position
		settle(40);

		// Random part: several register settings, extremes first.
		for (int p = 0; p < 10; p++) begin
			case (p)
				0: begin ax = 0;     bw = 1;    end
				1: begin ax = 16383; bw = 1024; end
				2: begin ax = 0;     bw = 0;    end   // zero width acts as one
				3: begin ax = 1200;  bw = 5;    end
				4: begin ax = 0;     bw = 1024; end
				5: begin ax = 16383; bw = 1;    end
				default: begin
					ax = $urandom_range(0, 3000);
					bw = $urandom_range(1, 64);
				end
			endcase
			cfg_write(pfr_pkg::REG_AXIS_START, ax);
			cfg_write(pfr_pkg::REG_BIN_WIDTH, bw);
			if (p == 0) begin
				// overfill the store: the last loads must be dropped
				push_profile(STORE_DEPTH + 6, c);
				push_search(peak_near(c > STORE_DEPTH - 1 ? STORE_DEPTH - 1 : c));
				settle(0);
			end
			start = pushed_total;
			while (pushed_total - start < PHASE_ITEMS) begin
				push_sequence();
				// sender holds off until the block has caught up
				if ($urandom_range(0, 9) == 0)
					settle(0);
			end
			settle(40);
		end

		settle(60);
		leftover = range_exp_q.size();
		if (leftover > 0)
			note_failure($sformatf("%0d expected results never arrived", leftover));
		$display("covered %0d requests, %0d searches (%0d on an empty store), %0d reg writes",
			reqs_seen, searches, empty_searches, cfg_writes);
		$display("%0d failures found", fail_count);
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/pfr_pkg.sv
rtl/pfr_in_if.sv
rtl/pfr_out_if.sv
rtl/pfr_front.sv
rtl/pfr_queue.sv
rtl/pfr_back.sv
rtl/peak_fraction_range_finder.sv
dv/tb_top.sv
